// ===== design/srbs_pkg.sv =====
package srbs_pkg;

	// default geometry of the search
	localparam int unsigned DEF_HALF_WINDOW = 10;
	localparam int unsigned DEF_SEARCH_SPAN = 5000;
	localparam int unsigned DEF_START_GAP   = 20;

	// fixed field widths
	localparam int unsigned COUNT_BITS = 23;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	// signed width of a centre position, with headroom for span and gap
	localparam int unsigned CTR_W      = POS_W + 2;

	// starting bound of the best fraction
	localparam int unsigned INIT_BOUND = 1000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHROM    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFTWARD = 2'd2;

	// kinds of result
	localparam logic [KIND_W-1:0] KIND_ANCHOR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REGR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd2;

	// datapath operations
	localparam int unsigned OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_EVAL   = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL0   = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL1   = 4'd4;
	localparam logic [OP_W-1:0] OP_MUL2   = 4'd5;
	localparam logic [OP_W-1:0] OP_MUL3   = 4'd6;
	localparam logic [OP_W-1:0] OP_MUL4   = 4'd7;
	localparam logic [OP_W-1:0] OP_CMP    = 4'd8;
	localparam logic [OP_W-1:0] OP_FINISH = 4'd9;

	typedef struct packed {
		logic [COUNT_BITS-1:0] match_count;
		logic [COUNT_BITS-1:0] mismatch_count;
		logic                  last_sample;
	} srbs_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  boundary_pos;
		logic [KIND_W-1:0] choice_kind;
	} srbs_out_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} srbs_cmd_t;

	typedef struct packed {
		logic eval_pending;
		logic cmp_pending;
		logic last;
		logic out_busy;
	} srbs_status_t;

endpackage

// ===== design/sliding_regression_boundary_search.sv =====
// sequence: a sample is loaded from idle and evaluated; an unscored centre goes straight to done,
// one outside the search range runs the evaluation only, and a scored one also runs the shared
// partial-product multiplier (four products and a compare per centre); a last sample's result is
// loaded by the finish in done, later while an earlier result is still stalled; no new sample
// is taken until the sequencer is back in idle, but one is taken while a loaded result waits
// reset: asynchronous, clears the window, sums, scan and control registers and loads the best bound
module sliding_regression_boundary_search #(
	parameter int unsigned HALF_WINDOW = srbs_pkg::DEF_HALF_WINDOW,
	parameter int unsigned SEARCH_SPAN = srbs_pkg::DEF_SEARCH_SPAN,
	parameter int unsigned START_GAP   = srbs_pkg::DEF_START_GAP
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  srbs_pkg::srbs_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output srbs_pkg::srbs_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [srbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srbs_pkg::*;

	srbs_cmd_t    cmd;
	srbs_status_t status;

	// sequencer
	srbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// window, sums and fraction compare
	srbs_datapath #(
		.HALF_WINDOW (HALF_WINDOW),
		.SEARCH_SPAN (SEARCH_SPAN),
		.START_GAP   (START_GAP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a transfer in always leaves the sequencer busy for the next cycle
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer ready straight after a transfer in");

	// finish only when the output register is free to load
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FINISH |-> !(out_valid && out_stall))
		else $error("result loaded over a pending result");

	// a finish always presents a result
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FINISH |=> out_valid)
		else $error("finish without a result");

	// the cross-multiply starts only after the fraction is formed
	a_mul_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_MUL0 |-> $past(cmd.op) == OP_EVAL)
		else $error("multiply started without evaluation");

endmodule

// ===== design/srbs_ctrl.sv =====
module srbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  srbs_pkg::srbs_status_t status,
	output srbs_pkg::srbs_cmd_t    cmd
);
	import srbs_pkg::*;

	localparam int unsigned ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_EVAL = 4'd1;
	localparam logic [ST_W-1:0] ST_M0   = 4'd2;
	localparam logic [ST_W-1:0] ST_M1   = 4'd3;
	localparam logic [ST_W-1:0] ST_M2   = 4'd4;
	localparam logic [ST_W-1:0] ST_M3   = 4'd5;
	localparam logic [ST_W-1:0] ST_M4   = 4'd6;
	localparam logic [ST_W-1:0] ST_CMP  = 4'd7;
	localparam logic [ST_W-1:0] ST_DONE = 4'd8;

	logic [ST_W-1:0] state_q;
	logic [ST_W-1:0] state_n;

	// next state and command
	always_comb begin
		state_n = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_n = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.eval_pending) begin
					cmd.op  = OP_EVAL;
					state_n = ST_M0;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_M0: begin
				if (status.cmp_pending) begin
					cmd.op  = OP_MUL0;
					state_n = ST_M1;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_M1: begin
				cmd.op  = OP_MUL1;
				state_n = ST_M2;
			end
			ST_M2: begin
				cmd.op  = OP_MUL2;
				state_n = ST_M3;
			end
			ST_M3: begin
				cmd.op  = OP_MUL3;
				state_n = ST_M4;
			end
			ST_M4: begin
				cmd.op  = OP_MUL4;
				state_n = ST_CMP;
			end
			ST_CMP: begin
				cmd.op  = OP_CMP;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!status.last) begin
					state_n = ST_IDLE;
				end else if (!status.out_busy) begin
					cmd.op  = OP_FINISH;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== design/srbs_datapath.sv =====
module srbs_datapath #(
	parameter int unsigned HALF_WINDOW = srbs_pkg::DEF_HALF_WINDOW,
	parameter int unsigned SEARCH_SPAN = srbs_pkg::DEF_SEARCH_SPAN,
	parameter int unsigned START_GAP   = srbs_pkg::DEF_START_GAP
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srbs_pkg::srbs_in_t                  in_data,
	input  logic                                cfg_we,
	input  logic [srbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  srbs_pkg::srbs_cmd_t                 cmd,
	output srbs_pkg::srbs_status_t              status,
	output logic                                out_valid,
	input  logic                                out_stall,
	output srbs_pkg::srbs_out_t                 out_data
);
	import srbs_pkg::*;

	// derived geometry and widths
	localparam int unsigned WIN_LEN  = 2 * HALF_WINDOW + 1;
	localparam int unsigned XX_SUM   = HALF_WINDOW * (HALF_WINDOW + 1) * WIN_LEN / 3;
	localparam int unsigned CAP      = 2 * HALF_WINDOW + SEARCH_SPAN;
	localparam int unsigned IDX_W    = $clog2(CAP + 1);
	localparam int unsigned HEAD_W   = $clog2(WIN_LEN);
	localparam int unsigned Y_W      = COUNT_BITS + 1;
	localparam int unsigned S_W      = Y_W + $clog2(WIN_LEN);
	localparam int unsigned W_W      = S_W + $clog2(HALF_WINDOW + 1) + 1;
	localparam int unsigned NUM_RAW  = S_W + $clog2(XX_SUM + 1);
	localparam int unsigned NUM_W    = (NUM_RAW > 20) ? NUM_RAW : 20;
	localparam int unsigned DEN_W    = W_W - 1 + $clog2(WIN_LEN + 1);
	localparam int unsigned HALF_D   = (DEN_W + 1) / 2;
	localparam int unsigned PP_W     = NUM_W + HALF_D;
	localparam int unsigned PROD_W   = NUM_W + DEN_W;

	localparam logic signed [W_W-1:0]   HW_S   = W_W'(HALF_WINDOW);
	localparam logic signed [W_W-1:0]   HW1_S  = W_W'(HALF_WINDOW + 1);
	localparam logic signed [CTR_W-1:0] HC_S   = CTR_W'(HALF_WINDOW);
	localparam logic signed [CTR_W-1:0] GAP_S  = CTR_W'(START_GAP);
	localparam logic signed [CTR_W-1:0] SPAN_S = CTR_W'(SEARCH_SPAN);
	localparam logic signed [CTR_W-1:0] FULL_S = CTR_W'(2 * HALF_WINDOW);

	// configuration
	logic [POS_W-1:0] anchor_q;
	logic [POS_W-1:0] chrom_q;
	logic             leftward_q;

	// scan state
	logic [Y_W-1:0]          win_q [WIN_LEN];
	logic [HEAD_W-1:0]       head_q;
	logic [S_W-1:0]          sum_q;
	logic signed [W_W-1:0]   wsum_q;
	logic [IDX_W-1:0]        idx_q;
	logic [NUM_W-1:0]        bn_q;
	logic [DEN_W-1:0]        bd_q;
	logic [POS_W-1:0]        bpos_q;
	logic [KIND_W-1:0]       bkind_q;
	logic                    won_q;
	logic                    eval_q;
	logic                    cmp_q;
	logic                    out_valid_q;

	// per-item working registers
	logic                    last_q;
	logic signed [CTR_W-1:0] ctr_q;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        den_q;
	logic [KIND_W-1:0]       kind_q;
	logic [PP_W-1:0]         pp_q;
	logic [PROD_W-1:0]       acc1_q;
	logic [PROD_W-1:0]       acc2_q;
	srbs_out_t               out_q;

	// window update
	logic [Y_W-1:0]          y_n;
	logic [Y_W-1:0]          old_n;
	logic signed [W_W-1:0]   old_s;
	logic signed [W_W-1:0]   y_s;
	logic signed [W_W-1:0]   sum_s;
	logic signed [W_W-1:0]   wsum_n;
	logic [S_W-1:0]          sum_n;
	logic                    in_cap;
	logic signed [CTR_W-1:0] anchor_s;
	logic signed [CTR_W-1:0] dist_s;
	logic signed [CTR_W-1:0] ctr_n;
	logic [HEAD_W-1:0]       head_n;

	always_comb begin
		y_n      = Y_W'(in_data.match_count) + Y_W'(in_data.mismatch_count);
		old_n    = win_q[head_q];
		old_s    = $signed(W_W'(old_n));
		y_s      = $signed(W_W'(y_n));
		sum_s    = $signed(W_W'(sum_q));
		wsum_n   = wsum_q + HW1_S * old_s - sum_s + HW_S * y_s;
		sum_n    = sum_q - S_W'(old_n) + S_W'(y_n);
		in_cap   = (idx_q < IDX_W'(CAP));
		anchor_s = $signed(CTR_W'(anchor_q));
		dist_s   = $signed(CTR_W'(idx_q)) - FULL_S;
		ctr_n    = leftward_q ? (anchor_s - GAP_S - dist_s) : (anchor_s + GAP_S + dist_s);
		head_n   = (head_q == HEAD_W'(WIN_LEN - 1)) ? '0 : head_q + HEAD_W'(1);
	end

	// centre evaluation: range, edges and the fraction
	logic signed [CTR_W-1:0] chrom_s;
	logic signed [CTR_W-1:0] low_s;
	logic                    in_range;
	logic                    edge_zero;
	logic [W_W-1:0]          wabs;
	logic [NUM_W-1:0]        num_n;
	logic [DEN_W-1:0]        den_n;
	logic [KIND_W-1:0]       kind_n;

	always_comb begin
		chrom_s  = $signed(CTR_W'(chrom_q));
		low_s    = (anchor_q < POS_W'(SEARCH_SPAN)) ? '0 : (anchor_s - SPAN_S);
		if (leftward_q) begin
			in_range = (anchor_q > POS_W'(START_GAP)) && (ctr_q > low_s);
		end else begin
			in_range = (ctr_q < chrom_s) && (ctr_q < anchor_s + SPAN_S);
		end
		edge_zero = (ctr_q < HC_S) || (ctr_q + HC_S >= chrom_s) || (sum_q == '0);
		wabs      = wsum_q[W_W-1] ? W_W'(-wsum_q) : W_W'(wsum_q);
		if (edge_zero) begin
			num_n  = '0;
			den_n  = DEN_W'(1);
			kind_n = KIND_EDGE;
		end else begin
			num_n  = NUM_W'(sum_q) * NUM_W'(XX_SUM);
			den_n  = DEN_W'(wabs) * DEN_W'(WIN_LEN);
			kind_n = KIND_REGR;
		end
	end

	// shared partial-product multiplier for the cross-multiply
	logic [NUM_W-1:0]  mul_a;
	logic [HALF_D-1:0] mul_b;
	logic [PP_W-1:0]   pp_n;

	always_comb begin
		case (cmd.op)
			OP_MUL0: begin
				mul_a = num_q;
				mul_b = bd_q[HALF_D-1:0];
			end
			OP_MUL1: begin
				mul_a = num_q;
				mul_b = HALF_D'(bd_q >> HALF_D);
			end
			OP_MUL2: begin
				mul_a = bn_q;
				mul_b = den_q[HALF_D-1:0];
			end
			default: begin
				mul_a = bn_q;
				mul_b = HALF_D'(den_q >> HALF_D);
			end
		endcase
		pp_n = PP_W'(mul_a) * PP_W'(mul_b);
	end

	// final position and kind, clamped below the chromosome length unless leftward from an anchor at or below the gap
	logic [POS_W-1:0]  fin_pos;
	logic [KIND_W-1:0] fin_kind;

	always_comb begin
		if (leftward_q && (anchor_q <= POS_W'(START_GAP))) begin
			fin_pos  = anchor_q;
			fin_kind = KIND_ANCHOR;
		end else begin
			fin_pos  = won_q ? bpos_q : anchor_q;
			fin_kind = won_q ? bkind_q : KIND_ANCHOR;
			if (fin_pos >= chrom_q) begin
				fin_pos = (chrom_q == '0) ? '0 : chrom_q - POS_W'(1);
			end
		end
	end

	// control and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q    <= '0;
			chrom_q     <= '0;
			leftward_q  <= 1'b0;
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			head_q      <= '0;
			sum_q       <= '0;
			wsum_q      <= '0;
			idx_q       <= '0;
			bn_q        <= NUM_W'(INIT_BOUND);
			bd_q        <= DEN_W'(1);
			bpos_q      <= '0;
			bkind_q     <= KIND_ANCHOR;
			won_q       <= 1'b0;
			eval_q      <= 1'b0;
			cmp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ANCHOR:   anchor_q   <= cfg_data[POS_W-1:0];
					REG_CHROM:    chrom_q    <= cfg_data[POS_W-1:0];
					REG_LEFTWARD: leftward_q <= cfg_data[0];
					default: ;
				endcase
			end
			// output register: transfer clears it, finish loads it
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					eval_q <= in_cap && (idx_q >= IDX_W'(2 * HALF_WINDOW));
					if (in_cap) begin
						win_q[head_q] <= y_n;
						head_q        <= head_n;
						sum_q         <= sum_n;
						wsum_q        <= wsum_n;
						idx_q         <= idx_q + IDX_W'(1);
					end
				end
				OP_EVAL: begin
					cmp_q <= in_range && (edge_zero || (wsum_q != '0));
				end
				OP_CMP: begin
					if (acc1_q < acc2_q) begin
						bn_q    <= num_q;
						bd_q    <= den_q;
						bpos_q  <= ctr_q[POS_W-1:0];
						bkind_q <= kind_q;
						won_q   <= 1'b1;
					end
				end
				OP_FINISH: begin
					for (int i = 0; i < WIN_LEN; i++) begin
						win_q[i] <= '0;
					end
					head_q  <= '0;
					sum_q   <= '0;
					wsum_q  <= '0;
					idx_q   <= '0;
					bn_q    <= NUM_W'(INIT_BOUND);
					bd_q    <= DEN_W'(1);
					bkind_q <= KIND_ANCHOR;
					won_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				last_q <= in_data.last_sample;
				ctr_q  <= ctr_n;
			end
			OP_EVAL: begin
				num_q  <= num_n;
				den_q  <= den_n;
				kind_q <= kind_n;
			end
			OP_MUL0: begin
				pp_q <= pp_n;
			end
			OP_MUL1: begin
				acc1_q <= PROD_W'(pp_q);
				pp_q   <= pp_n;
			end
			OP_MUL2: begin
				acc1_q <= acc1_q + (PROD_W'(pp_q) << HALF_D);
				pp_q   <= pp_n;
			end
			OP_MUL3: begin
				acc2_q <= PROD_W'(pp_q);
				pp_q   <= pp_n;
			end
			OP_MUL4: begin
				acc2_q <= acc2_q + (PROD_W'(pp_q) << HALF_D);
			end
			OP_FINISH: begin
				out_q.boundary_pos <= fin_pos;
				out_q.choice_kind  <= fin_kind;
			end
			default: ;
		endcase
	end

	assign status.eval_pending = eval_q;
	assign status.cmp_pending  = cmp_q;
	assign status.last         = last_q;
	assign status.out_busy     = out_valid_q && out_stall;
	assign out_valid           = out_valid_q;
	assign out_data            = out_q;

endmodule

// ===== bench/srbs_boundary_checker.sv =====
`timescale 1ns / 100ps

module srbs_boundary_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  srbs_pkg::srbs_in_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  srbs_pkg::srbs_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [srbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding
);
	import srbs_pkg::*;

	localparam longint HW       = DEF_HALF_WINDOW;
	localparam longint GAP      = DEF_START_GAP;
	localparam longint SPAN     = DEF_SEARCH_SPAN;
	localparam int     WIN_LEN  = 2 * DEF_HALF_WINDOW + 1;
	localparam longint XX_SUM   = HW * (HW + 1) * (2 * HW + 1) / 3;
	localparam int     SCAN_CAP = 2 * DEF_HALF_WINDOW + DEF_SEARCH_SPAN;

	// register copies
	logic [POS_W-1:0]      anchor_q;
	logic [POS_W-1:0]      chrom_q;
	logic                  leftward_q;

	// window and running sums
	logic [COUNT_BITS:0]   win_y [WIN_LEN];
	int                    win_head;
	longint                run_sum;
	longint                run_wsum;
	int                    scan_idx;

	// best centre so far
	logic [63:0]           lead_num;
	logic [63:0]           lead_den;
	logic [POS_W-1:0]      lead_pos;
	logic [KIND_W-1:0]     lead_kind;
	bit                    lead_won;

	srbs_out_t             expected_boundaries[$];
	int                    fails;

	task automatic clear_scan();
		for (int i = 0; i < WIN_LEN; i++)
			win_y[i] = '0;
		win_head  = 0;
		run_sum   = 0;
		run_wsum  = 0;
		scan_idx  = 0;
		lead_num  = 64'(INIT_BOUND);
		lead_den  = 64'd1;
		lead_pos  = anchor_q;
		lead_kind = KIND_ANCHOR;
		lead_won  = 1'b0;
	endtask

	// exact fraction compare of one centre against the best one
	task automatic score_centre(input longint c);
		logic [63:0]       num;
		logic [63:0]       den;
		logic [KIND_W-1:0] kind;
		logic [127:0]      lhs;
		logic [127:0]      rhs;
		longint            chrom_l;
		longint            aw;
		chrom_l = {32'd0, chrom_q};
		if (c < HW || c + HW >= chrom_l || run_sum == 0) begin
			num  = 64'd0;
			den  = 64'd1;
			kind = KIND_EDGE;
		end else if (run_wsum == 0) begin
			return;
		end else begin
			aw   = (run_wsum < 0) ? -run_wsum : run_wsum;
			num  = XX_SUM * run_sum;
			den  = WIN_LEN * aw;
			kind = KIND_REGR;
		end
		lhs = {64'd0, num} * {64'd0, lead_den};
		rhs = {64'd0, lead_num} * {64'd0, den};
		if (lhs < rhs) begin
			lead_num  = num;
			lead_den  = den;
			lead_pos  = c[POS_W-1:0];
			lead_kind = kind;
			lead_won  = 1'b1;
		end
	endtask

	// window update, centre scoring and the boundary at the end of a search
	task automatic take_sample(input srbs_in_t s);
		logic [COUNT_BITS:0] y;
		longint              yl;
		longint              ol;
		longint              d;
		longint              a;
		longint              c;
		longint              floor_pos;
		longint              chrom_l;
		srbs_out_t           res;
		y = {1'b0, s.match_count} + {1'b0, s.mismatch_count};
		if (scan_idx < SCAN_CAP) begin
			yl       = {40'd0, y};
			ol       = {40'd0, win_y[win_head]};
			run_wsum = run_wsum + HW * ol + ol - run_sum + HW * yl;
			run_sum  = run_sum - ol + yl;
			win_y[win_head] = y;
			win_head = (win_head + 1 == WIN_LEN) ? 0 : win_head + 1;
			if (scan_idx >= 2 * HW) begin
				d       = scan_idx - 2 * HW;
				a       = {32'd0, anchor_q};
				chrom_l = {32'd0, chrom_q};
				if (leftward_q) begin
					c         = a - GAP - d;
					floor_pos = (a < SPAN) ? 0 : a - SPAN;
					if (a > GAP && c > floor_pos)
						score_centre(c);
				end else begin
					c = a + GAP + d;
					if (c < chrom_l && c < a + SPAN)
						score_centre(c);
				end
			end
			scan_idx++;
		end
		if (s.last_sample) begin
			if (leftward_q && {32'd0, anchor_q} <= GAP) begin
				res.boundary_pos = anchor_q;
				res.choice_kind  = KIND_ANCHOR;
			end else begin
				res.boundary_pos = lead_won ? lead_pos : anchor_q;
				res.choice_kind  = lead_won ? lead_kind : KIND_ANCHOR;
				if (res.boundary_pos >= chrom_q)
					res.boundary_pos = (chrom_q == 0) ? '0 : chrom_q - 1;
			end
			expected_boundaries.push_back(res);
			clear_scan();
		end
	endtask

	// watch the configuration port and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q   = '0;
			chrom_q    = '0;
			leftward_q = 1'b0;
			clear_scan();
			expected_boundaries.delete();
			fails = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANCHOR:   anchor_q = cfg_data;
					REG_CHROM:    chrom_q = cfg_data;
					REG_LEFTWARD: leftward_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_sample(in_data);
			// compare each result transfer with the oldest expected boundary
			if (out_valid && !out_stall) begin
				if (expected_boundaries.size() == 0) begin
					$error("unexpected result: boundary_pos %0d choice_kind %0d",
						out_data.boundary_pos, out_data.choice_kind);
					fails++;
				end else begin
					automatic srbs_out_t want = expected_boundaries.pop_front();
					if (out_data.boundary_pos !== want.boundary_pos) begin
						$error("boundary_pos: expected %0d, got %0d",
							want.boundary_pos, out_data.boundary_pos);
						fails++;
					end
					if (out_data.choice_kind !== want.choice_kind) begin
						$error("choice_kind: expected %0d, got %0d",
							want.choice_kind, out_data.choice_kind);
						fails++;
					end
				end
			end
			fail_count  <= fails;
			outstanding <= expected_boundaries.size();
		end
	end

endmodule

// ===== bench/tb_sliding_regression_boundary_search.sv =====
`timescale 1ns / 100ps

module tb_sliding_regression_boundary_search;
	import srbs_pkg::*;

	localparam int     RANDOM_ITEMS  = 950;
	localparam int     MIN_SEARCHES  = 20;
	localparam int     SETTLE_CYCLES = 12;
	localparam int     DRAIN_CYCLES  = 20;
	localparam longint WATCHDOG_NS   = 20_000_000;

	typedef enum int {
		PAT_RANDOM,
		PAT_ZERO,
		PAT_FLAT,
		PAT_RAMP,
		PAT_STEP,
		PAT_MAX
	} tally_pat_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	srbs_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	srbs_out_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ANCHOR;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int  fail_count;
	int  outstanding;
	bit  calm = 1'b0;
	int  stall_left = 0;
	int  roll;
	int  n_samples = 0;
	int  n_scans = 0;
	int  n_left = 0;

	always #4 clk = ~clk;

	sliding_regression_boundary_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	srbs_boundary_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// result side back-pressure: mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				out_stall <= 1'b0;
			end else if (roll < 95) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(5, 40);
				out_stall <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	function automatic logic [COUNT_BITS-1:0] rand_tally();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return COUNT_BITS'($urandom_range(0, 255));
			4, 5:    return COUNT_BITS'($urandom_range(0, 65535));
			default: return COUNT_BITS'($urandom);
		endcase
	endfunction

	// search setups: ordinary, near the ends of the chromosome, and the extremes
	task automatic pick_setup(output logic [31:0] anchor, output logic [31:0] chrom,
			output logic leftward);
		case ($urandom_range(0, 5))
			0: begin
				leftward = 1'b0;
				anchor   = $urandom_range(0, 100000);
				chrom    = anchor + $urandom_range(0, 120);
			end
			1: begin
				leftward = 1'b1;
				anchor   = $urandom_range(0, 120);
				chrom    = $urandom_range(0, 200);
			end
			2: begin
				leftward = $urandom_range(0, 1);
				anchor   = $urandom;
				chrom    = $urandom;
			end
			3: begin
				leftward = $urandom_range(0, 1);
				anchor   = $urandom_range(21, 5000);
				chrom    = 32'hFFFF_FFFF;
			end
			4: begin
				leftward = $urandom_range(0, 1);
				case ($urandom_range(0, 3))
					0:       anchor = 32'd0;
					1:       anchor = 32'hFFFF_FFFF;
					2:       anchor = 32'hFFFF_FFFF - $urandom_range(0, 60);
					default: anchor = $urandom_range(0, 20);
				endcase
				case ($urandom_range(0, 2))
					0:       chrom = 32'd0;
					1:       chrom = 32'hFFFF_FFFF;
					default: chrom = $urandom_range(0, 60);
				endcase
			end
			default: begin
				leftward = $urandom_range(0, 1);
				anchor   = $urandom_range(1000, 1000000);
				chrom    = anchor + $urandom_range(30, 90);
			end
		endcase
	endtask

	// one search: wait for idle, set the registers, stream the tallies
	task automatic run_scan(input logic [31:0] anchor, input logic [31:0] chrom,
			input logic leftward, input int len, input tally_pat_e pat, input bit quiet);
		srbs_in_t              s;
		logic [COUNT_BITS-1:0] base_m;
		logic [COUNT_BITS-1:0] base_mm;
		int                    rise_at;
		int                    ramp_inc;
		int                    gap;
		base_m   = rand_tally();
		base_mm  = rand_tally();
		rise_at  = $urandom_range(0, len);
		ramp_inc = $urandom_range(1, 4096);
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		calm      <= quiet;
		cfg_we    <= 1'b1;
		cfg_index <= REG_ANCHOR;
		cfg_data  <= anchor;
		@(posedge clk);
		cfg_index <= REG_CHROM;
		cfg_data  <= chrom;
		@(posedge clk);
		cfg_index <= REG_LEFTWARD;
		cfg_data  <= CFG_DATA_W'(leftward);
		@(posedge clk);
		cfg_we    <= 1'b0;
		for (int k = 0; k < len; k++) begin
			case (pat)
				PAT_ZERO: begin
					s.match_count    = '0;
					s.mismatch_count = '0;
				end
				PAT_FLAT: begin
					s.match_count    = base_m;
					s.mismatch_count = base_mm;
				end
				PAT_RAMP: begin
					s.match_count    = COUNT_BITS'(k * ramp_inc);
					s.mismatch_count = '0;
				end
				PAT_STEP: begin
					s.match_count    = (k >= rise_at) ? base_m : COUNT_BITS'($urandom_range(0, 3));
					s.mismatch_count = COUNT_BITS'($urandom_range(0, 3));
				end
				PAT_MAX: begin
					s.match_count    = '1;
					s.mismatch_count = '1;
				end
				default: begin
					s.match_count    = rand_tally();
					s.mismatch_count = rand_tally();
				end
			endcase
			s.last_sample = (k == len - 1);
			gap = quiet ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// hold the sample until the transfer
			in_valid <= 1'b1;
			in_data  <= s;
			do
				@(posedge clk);
			while (in_stall);
		end
		in_valid <= 1'b0;
		n_scans++;
		n_samples += len;
		if (leftward)
			n_left++;
	endtask

	initial begin
		logic [31:0] anchor;
		logic [31:0] chrom;
		logic        leftward;
		int          len;
		int          r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty chromosome with full-scale tallies, small anchor leftward,
		// a step edge scored near the end of a short chromosome
		run_scan(32'd0, 32'd0, 1'b0, 1, PAT_MAX, 1'b0);
		run_scan(32'd20, 32'hFFFF_FFFF, 1'b1, 2, PAT_RANDOM, 1'b0);
		run_scan(32'd100, 32'd135, 1'b0, 22, PAT_STEP, 1'b1);

		// random searches
		while (n_samples < RANDOM_ITEMS || n_scans < MIN_SEARCHES) begin
			pick_setup(anchor, chrom, leftward);
			r = $urandom_range(0, 99);
			if (r < 12)
				len = $urandom_range(1, 20);
			else if (r < 85)
				len = $urandom_range(21, 45);
			else
				len = $urandom_range(46, 120);
			run_scan(anchor, chrom, leftward, len,
				tally_pat_e'($urandom_range(PAT_RANDOM, PAT_MAX)),
				$urandom_range(0, 4) == 0);
		end

		// drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples over %0d searches, %0d of them leftward,",
			n_samples, n_scans, n_left);
		$display("with random gaps and stalls, chromosome ends, small anchors and flat windows");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("status: fail");
		$finish;
	end

endmodule
